@@ sv/usr_pkg.sv @@
package usr_pkg;

  localparam int MAX_DATA_BITS = 8;
  localparam int DATA_W        = 8;
  localparam int COUNT_W       = 4;
  localparam int PERIOD_W      = 16;
  localparam int TIMER_W       = 17;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_CHECK = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PARITY  = 2'd1;
  localparam logic [1:0] ST_FRAMING = 2'd2;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd5208;
  localparam logic [COUNT_W-1:0]  DATA_BITS_RST  = 4'd8;

  typedef enum logic [4:0] {
    PH_AWAIT  = 5'b00001,
    PH_DATA   = 5'b00010,
    PH_PARITY = 5'b00100,
    PH_STOP   = 5'b01000,
    PH_HALT   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] bit_period;
    logic [COUNT_W-1:0]  data_bits;
    logic                parity_check;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] data;
  } res_t;

endpackage

@@ sv/usr_core.sv @@
module usr_core (
  input  logic                clk,
  input  logic                rst,
  input  usr_pkg::cfg_t       cfg,
  input  logic                accept,
  input  logic                line_level,
  output logic                push,
  output usr_pkg::res_t       res
);

  usr_pkg::phase_t                    phase, phase_next;
  logic [usr_pkg::TIMER_W-1:0]        countdown, countdown_next;
  logic [usr_pkg::DATA_W-1:0]         shift_data, shift_data_next;
  logic [usr_pkg::COUNT_W-1:0]        bit_count, bit_count_next;
  logic                               last_level;

  logic                               changed;
  logic [usr_pkg::TIMER_W-1:0]        cd_dec;
  logic                               expire;
  logic                               take;
  logic [usr_pkg::TIMER_W-1:0]        long_reload;
  logic [usr_pkg::TIMER_W-1:0]        short_reload;
  logic [usr_pkg::COUNT_W-1:0]        frame_len;
  logic [usr_pkg::COUNT_W-1:0]        count_inc;
  logic                               good;

  assign changed      = line_level != last_level;
  assign cd_dec       = (countdown != '0) ? countdown - 1'b1 : countdown;
  assign expire       = cd_dec == '0;
  assign take         = changed | expire;
  assign short_reload = {1'b0, cfg.bit_period};
  assign long_reload  = {1'b0, cfg.bit_period} + {2'b0, cfg.bit_period[usr_pkg::PERIOD_W-1:1]};
  assign count_inc    = bit_count + 1'b1;
  // odd parity: data ones plus parity bit odd
  assign good         = !cfg.parity_check || ((^shift_data) != line_level);

  always_comb begin
    if (cfg.data_bits == '0) begin
      frame_len = usr_pkg::COUNT_W'(1);
    end else if (cfg.data_bits > usr_pkg::COUNT_W'(usr_pkg::MAX_DATA_BITS)) begin
      frame_len = usr_pkg::COUNT_W'(usr_pkg::MAX_DATA_BITS);
    end else begin
      frame_len = cfg.data_bits;
    end
  end

  always_comb begin
    phase_next      = phase;
    countdown_next  = countdown;
    shift_data_next = shift_data;
    bit_count_next  = bit_count;
    push            = 1'b0;
    res.status      = usr_pkg::ST_OK;
    res.data        = '0;
    unique case (phase)
      usr_pkg::PH_AWAIT: begin
        if (line_level) begin
          countdown_next  = long_reload;
          phase_next      = usr_pkg::PH_DATA;
          shift_data_next = '0;
          bit_count_next  = '0;
        end
      end
      usr_pkg::PH_DATA, usr_pkg::PH_PARITY: begin
        countdown_next = changed ? long_reload : (expire ? short_reload : cd_dec);
        if (take) begin
          if (phase == usr_pkg::PH_DATA) begin
            if (line_level && bit_count < usr_pkg::COUNT_W'(usr_pkg::DATA_W)) begin
              shift_data_next = shift_data |
                (usr_pkg::DATA_W'(1) << bit_count[$clog2(usr_pkg::DATA_W)-1:0]);
            end
            bit_count_next = count_inc;
            if (count_inc >= frame_len) begin
              phase_next = usr_pkg::PH_PARITY;
            end
          end else begin
            push       = accept;
            res.status = good ? usr_pkg::ST_OK : usr_pkg::ST_PARITY;
            res.data   = good ? shift_data : '0;
            phase_next = usr_pkg::PH_STOP;
          end
        end
      end
      usr_pkg::PH_STOP: begin
        // level change takes the stop bit without touching the timer
        if (!changed) begin
          countdown_next = cd_dec;
        end
        if (take) begin
          if (!line_level) begin
            phase_next = usr_pkg::PH_AWAIT;
          end else begin
            push       = accept;
            res.status = usr_pkg::ST_FRAMING;
            phase_next = usr_pkg::PH_HALT;
          end
        end
      end
      usr_pkg::PH_HALT: begin
      end
      default: begin
        phase_next = usr_pkg::PH_AWAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= usr_pkg::PH_AWAIT;
      countdown  <= '0;
      shift_data <= '0;
      bit_count  <= '0;
      last_level <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      countdown  <= countdown_next;
      shift_data <= shift_data_next;
      bit_count  <= bit_count_next;
      last_level <= line_level;
    end
  end

endmodule

@@ sv/usr_out_buf.sv @@
module usr_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  usr_pkg::res_t res_in,
  output logic          full,
  output logic          result_valid,
  input  logic          result_stall,
  output usr_pkg::res_t res_out
);

  logic          skid_valid;
  usr_pkg::res_t skid;
  logic          out_free;

  assign full     = skid_valid;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= push;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res_out <= skid_valid ? skid : res_in;
      skid    <= res_in;
    end else if (push) begin
      skid <= res_in;
    end
  end

endmodule

@@ sv/uart_sampling_receiver.sv @@
// Channel   Handshake                      Payload
// sample    sample_valid / sample_stall    line_level
// result    result_valid / result_stall    status, data
// config    cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One line sample per cycle unless sample_stall is high; the frame state
// loads at the edge that accepts a sample, and a finished result is
// registered there too, into the output register or, if busy, the skid.
// Reset is synchronous: awaiting start bit, timer zero, registers to defaults.
// sample_stall rises only when both the output register and the skid
// register hold results; cfg_ready is always high.
module uart_sampling_receiver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic                              line_level,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [1:0]                        status,
  output logic [usr_pkg::DATA_W-1:0]        data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [usr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [usr_pkg::PERIOD_W-1:0]      cfg_data
);

  usr_pkg::cfg_t cfg;
  usr_pkg::res_t core_res;
  usr_pkg::res_t res_out;
  logic          accept;
  logic          push;

  assign cfg_ready = 1'b1;
  assign accept    = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_period   <= usr_pkg::BIT_PERIOD_RST;
      cfg.data_bits    <= usr_pkg::DATA_BITS_RST;
      cfg.parity_check <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        usr_pkg::CFG_BIT_PERIOD:   cfg.bit_period   <= cfg_data;
        usr_pkg::CFG_DATA_BITS:    cfg.data_bits    <= cfg_data[usr_pkg::COUNT_W-1:0];
        usr_pkg::CFG_PARITY_CHECK: cfg.parity_check <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  usr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .line_level (line_level),
    .push       (push),
    .res        (core_res)
  );

  usr_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .res_in       (core_res),
    .full         (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res_out      (res_out)
  );

  assign status = res_out.status;
  assign data   = res_out.data;

endmodule

@@ bench/uart_rx_checker.sv @@
module uart_rx_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  input  logic                          sample_stall,
  input  logic                          line_level,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [1:0]                    status,
  input  logic [usr_pkg::DATA_W-1:0]    data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [usr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [usr_pkg::PERIOD_W-1:0]  cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            checked
);
  timeunit 1ns;
  timeprecision 1ps;

  usr_pkg::cfg_t                regs;
  usr_pkg::phase_t              phase;
  logic [usr_pkg::TIMER_W-1:0]  countdown;
  logic [usr_pkg::DATA_W-1:0]   shifted;
  logic [usr_pkg::COUNT_W-1:0]  got_bits;
  logic                         prev_level;
  usr_pkg::res_t                expected_q[$];
  int                           n_err = 0;
  int                           n_checked = 0;
  int                           n_pending = 0;

  assign errors  = n_err;
  assign checked = n_checked;
  assign pending = n_pending;

  function automatic int frame_bits();
    if (regs.data_bits == 0) return 1;
    if (regs.data_bits > usr_pkg::MAX_DATA_BITS) return usr_pkg::MAX_DATA_BITS;
    return regs.data_bits;
  endfunction

  function automatic logic [usr_pkg::TIMER_W-1:0] period_and_half();
    return usr_pkg::TIMER_W'(regs.bit_period) + usr_pkg::TIMER_W'(regs.bit_period >> 1);
  endfunction

  // Edge on the line resyncs to mid-bit; otherwise the timer paces the sample.
  function automatic logic sample_due(input logic lv);
    if (lv != prev_level) begin
      countdown = period_and_half();
      return 1'b1;
    end
    if (countdown != 0) countdown = countdown - 1'b1;
    if (countdown == 0) begin
      countdown = usr_pkg::TIMER_W'(regs.bit_period);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic take_sample(input logic lv);
    logic good;
    logic stop_now;
    usr_pkg::res_t r;
    unique case (phase)
      usr_pkg::PH_AWAIT: begin
        if (lv) begin
          countdown = period_and_half();
          phase     = usr_pkg::PH_DATA;
          shifted   = '0;
          got_bits  = '0;
        end
      end
      usr_pkg::PH_DATA: begin
        if (sample_due(lv)) begin
          if (lv && got_bits < usr_pkg::DATA_W) shifted[got_bits] = 1'b1;
          got_bits = got_bits + 1'b1;
          if (got_bits >= frame_bits()) phase = usr_pkg::PH_PARITY;
        end
      end
      usr_pkg::PH_PARITY: begin
        if (sample_due(lv)) begin
          // odd parity: data ones plus parity bit must be odd
          good     = !regs.parity_check || ((^shifted) != lv);
          r.status = good ? usr_pkg::ST_OK : usr_pkg::ST_PARITY;
          r.data   = good ? shifted : '0;
          expected_q = {expected_q, r};
          phase = usr_pkg::PH_STOP;
        end
      end
      usr_pkg::PH_STOP: begin
        stop_now = (lv != prev_level);
        if (!stop_now) begin
          if (countdown != 0) countdown = countdown - 1'b1;
          stop_now = (countdown == 0);
        end
        if (stop_now) begin
          if (!lv) begin
            phase = usr_pkg::PH_AWAIT;
          end else begin
            r.status = usr_pkg::ST_FRAMING;
            r.data   = '0;
            expected_q = {expected_q, r};
            phase = usr_pkg::PH_HALT;
          end
        end
      end
      default: ;
    endcase
    prev_level = lv;
  endtask

  always @(posedge clk) begin
    usr_pkg::res_t want;
    if (rst) begin
      regs.bit_period   = usr_pkg::BIT_PERIOD_RST;
      regs.data_bits    = usr_pkg::DATA_BITS_RST;
      regs.parity_check = 1'b0;
      phase      = usr_pkg::PH_AWAIT;
      countdown  = '0;
      shifted    = '0;
      got_bits   = '0;
      prev_level = 1'b0;
      expected_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result status %0d data 0x%02h", $time, status, data);
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (status !== want.status) begin
            n_err++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
          if (data !== want.data) begin
            n_err++;
            $display("%0t: data expected 0x%02h actual 0x%02h", $time, want.data, data);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          usr_pkg::CFG_BIT_PERIOD:   regs.bit_period   = cfg_data;
          usr_pkg::CFG_DATA_BITS:    regs.data_bits    = cfg_data[usr_pkg::COUNT_W-1:0];
          usr_pkg::CFG_PARITY_CHECK: regs.parity_check = cfg_data[0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) take_sample(line_level);
    end
    n_pending <= expected_q.size();
  end

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [usr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          sample_valid = 1'b0;
  logic                          line_level = 1'b0;
  logic                          result_stall = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [usr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [usr_pkg::PERIOD_W-1:0]  cfg_data = '0;
  logic                          sample_stall;
  logic                          result_valid;
  logic                          cfg_ready;
  logic [1:0]                    status;
  logic [usr_pkg::DATA_W-1:0]    data;
  int                            errors;
  int                            pending;
  int                            checked;

  int period_now = int'(usr_pkg::BIT_PERIOD_RST);
  int len_now = int'(usr_pkg::DATA_BITS_RST);
  bit calm = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int stall_left = 0;
  int n_sent = 0;
  int n_frames = 0;
  int n_writes = 0;
  int n_blocked = 0;

  uart_sampling_receiver uut (.*);
  uart_rx_checker rx_check (.*);

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done    <= 1'b1;
      stall_left   <= 399;
      result_stall <= 1'b1;
    end else if (!calm && recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic int idle_odds();
    unique case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 15;
    endcase
  endfunction

  function automatic int bit_ticks();
    return (period_now < 1) ? 1 : period_now;
  endfunction

  task automatic put_level(input logic lv);
    int gap;
    if (!calm && send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      gap = $urandom_range(1, 9);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    line_level   <= lv;
    @(posedge clk);
    while (sample_stall) begin
      n_blocked++;
      @(posedge clk);
    end
    n_sent++;
  endtask

  task automatic hold_level(input logic lv, input int ticks);
    repeat (ticks) put_level(lv);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [usr_pkg::CFG_IDX_W-1:0] idx,
                         input logic [usr_pkg::PERIOD_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_writes++;
    if (idx == usr_pkg::CFG_BIT_PERIOD)
      period_now = int'(v);
    else if (idx == usr_pkg::CFG_DATA_BITS)
      len_now = (v[3:0] == 0) ? 1 :
                ((v[3:0] > usr_pkg::MAX_DATA_BITS) ? usr_pkg::MAX_DATA_BITS : int'(v[3:0]));
  endtask

  // upper data bits are junk on purpose: the narrow registers must drop them
  task automatic configure(input int p, input logic [3:0] code, input logic par);
    wait_idle();
    set_reg(usr_pkg::CFG_BIT_PERIOD, 16'(p));
    set_reg(usr_pkg::CFG_DATA_BITS, {12'($urandom), code});
    set_reg(usr_pkg::CFG_PARITY_CHECK, {15'($urandom), par});
    if ($urandom_range(0, 3) == 0) set_reg(CFG_SPARE, 16'($urandom));
    send_idle_pct = idle_odds();
    recv_idle_pct = idle_odds();
  endtask

  task automatic send_frame(input logic [7:0] d, input logic par_ok, input logic stop_hi,
                            input int ticks);
    logic [7:0] m;
    logic       pb;
    m  = d & (8'hFF >> (usr_pkg::DATA_W - len_now));
    pb = par_ok ? ~(^m) : (^m);
    hold_level(1'b1, ticks);
    for (int i = 0; i < len_now; i++) hold_level(m[i], ticks);
    hold_level(pb, ticks);
    hold_level(stop_hi, ticks);
    n_frames++;
  endtask

  // short high glitch: block frames all-zero data; long low tail lets it finish
  task automatic send_runt();
    int w;
    w = $urandom_range(1, bit_ticks());
    hold_level(1'b1, w);
    hold_level(1'b0, (len_now + 4) * bit_ticks() + 2);
    n_frames++;
  endtask

  task automatic line_gap();
    hold_level(1'b0, $urandom_range(0, 2 * bit_ticks()));
  endtask

  initial begin
    int start_items;
    int start_frames;
    int p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    configure(3, 4'd8, 1'b0);
    send_frame(8'h00, 1'b1, 1'b0, bit_ticks());
    send_frame(8'hFF, 1'b1, 1'b0, bit_ticks());
    send_frame(8'hA5, 1'b0, 1'b0, bit_ticks());
    send_runt();
    configure(3, 4'd8, 1'b1);
    send_frame(8'h5A, 1'b1, 1'b0, bit_ticks());
    send_frame(8'h5A, 1'b0, 1'b0, bit_ticks());
    send_frame(8'h00, 1'b1, 1'b0, bit_ticks());
    send_frame(8'hFF, 1'b0, 1'b0, bit_ticks());
    configure(2, 4'd1, 1'b1);
    send_frame(8'h01, 1'b1, 1'b0, bit_ticks());
    send_frame(8'h00, 1'b0, 1'b0, bit_ticks());
    configure(2, 4'd0, 1'b0);
    send_frame(8'h01, 1'b1, 1'b0, bit_ticks());
    send_frame(8'h00, 1'b1, 1'b0, bit_ticks());
    configure(5, 4'd15, 1'b1);
    send_frame(8'h81, 1'b1, 1'b0, bit_ticks());
    send_frame(8'h3C, 1'b0, 1'b0, bit_ticks());
    configure(4, 4'd7, 1'b0);
    send_frame(8'h7F, 1'b1, 1'b0, bit_ticks());
    configure(0, 4'd5, 1'b1);
    send_frame(8'($urandom), 1'b1, 1'b0, bit_ticks());
    send_runt();
    configure(1, 4'd3, 1'b0);
    send_frame(8'($urandom), 1'b0, 1'b0, bit_ticks());
    line_gap();
    // longest period: only toggling frames, every bit taken on a line edge
    configure(65535, 4'd1, 1'b1);
    send_frame(8'h00, 1'b1, 1'b0, 1);
    configure(65535, 4'd7, 1'b0);
    send_frame(8'h2A, 1'b0, 1'b0, 1);
    hold_level(1'b0, 4);

    // back-pressure: fast frames while the result side holds off
    configure(0, 4'd1, 1'b0);
    hold_req = 1'b1;
    repeat (40) send_frame(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1);

    start_items  = n_sent;
    start_frames = n_frames;
    while (n_sent - start_items < 380 || n_frames - start_frames < 8) begin
      unique case ($urandom_range(0, 9))
        0:       p = 0;
        1:       p = 1;
        8:       p = $urandom_range(7, 16);
        default: p = $urandom_range(2, 6);
      endcase
      configure(p, 4'($urandom), 1'($urandom));
      repeat ($urandom_range(3, 6)) begin
        if ($urandom_range(0, 9) == 0)
          send_runt();
        else
          send_frame(8'($urandom), $urandom_range(0, 4) != 0, 1'b0, bit_ticks());
        line_gap();
      end
    end

    calm = 1'b1;
    configure(2, 4'd8, 1'b1);
    repeat (5) begin
      send_frame(8'($urandom), $urandom_range(0, 3) != 0, 1'b0, bit_ticks());
      line_gap();
    end
    // high stop bit: framing error, then the receiver ignores the line
    send_frame(8'($urandom), 1'b1, 1'b1, bit_ticks());
    repeat (16) put_level(1'($urandom));

    sample_valid <= 1'b0;
    repeat (2) @(posedge clk);
    for (int i = 0; i < 5000 && pending != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);

    $display("Drove %0d line samples in %0d frames with %0d register writes;",
             n_sent, n_frames, n_writes);
    $display("input stalled %0d cycles; compared %0d data, parity and framing results.",
             n_blocked, checked);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/usr_pkg.sv
sv/usr_core.sv
sv/usr_out_buf.sv
sv/uart_sampling_receiver.sv
bench/uart_rx_checker.sv
bench/tb.sv
